// ----- src/lcpd_pkg.sv -----
// Shared types and constants for the length/checksum packet deframer.
package lcpd_pkg;

	localparam int unsigned BYTE_W = 8;
	localparam int unsigned SUM_W  = 17;
	localparam int unsigned RES_W  = 7;

	localparam logic [BYTE_W-1:0] MIN_LEN  = 8'd2;
	localparam logic [RES_W-1:0]  MODULUS  = 7'd71;
	// 3412 mod 71: residue of an empty sum
	localparam logic [RES_W-1:0]  RES_INIT = 7'd4;
	// payload sums below this leave the offset sum negative
	localparam logic signed [SUM_W-1:0] SUM_FLOOR = -17'sd3412;

	localparam logic [1:0] ST_BUSY   = 2'd0;
	localparam logic [1:0] ST_GOOD   = 2'd1;
	localparam logic [1:0] ST_BAD    = 2'd2;
	localparam logic [1:0] ST_BADLEN = 2'd3;

	typedef enum logic [1:0] {
		PH_LEN,
		PH_CHK,
		PH_TYPE,
		PH_DATA
	} phase_t;

	typedef enum logic [1:0] {
		K_DATA,
		K_EMPTY,
		K_BADLEN
	} kind_t;

	typedef struct packed {
		kind_t             kind;
		logic [BYTE_W-1:0] data;
		logic [BYTE_W-1:0] ptype;
		logic [BYTE_W-1:0] chk;
		logic              last;
	} entry_t;

endpackage

// ----- src/lcpd_front.sv -----
// Front end: frame header parser that turns payload bytes, bad lengths and empty frames into queue entries.
module lcpd_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [7:0]            in_byte,
	input  logic                  q_full,
	output logic                  push,
	output lcpd_pkg::entry_t      push_entry
);
	import lcpd_pkg::*;

	phase_t            phase_q, phase_nx;
	logic [BYTE_W-1:0] left_q;
	logic [BYTE_W-1:0] chk_q;
	logic [BYTE_W-1:0] type_q;
	logic              acc;

	assign in_ready = !q_full;
	assign acc      = in_valid && !q_full;

	always_comb begin
		phase_nx = phase_q;
		case (phase_q)
			PH_LEN: begin
				if (in_byte >= MIN_LEN) phase_nx = PH_CHK;
			end
			PH_CHK:  phase_nx = PH_TYPE;
			PH_TYPE: begin
				phase_nx = (left_q == '0) ? PH_LEN : PH_DATA;
			end
			PH_DATA: begin
				if (left_q == 8'd1) phase_nx = PH_LEN;
			end
			default: phase_nx = PH_LEN;
		endcase
	end

	always_comb begin
		push             = 1'b0;
		push_entry.kind  = K_DATA;
		push_entry.data  = in_byte;
		push_entry.ptype = type_q;
		push_entry.chk   = chk_q;
		push_entry.last  = 1'b0;
		case (phase_q)
			PH_LEN: begin
				push             = acc && (in_byte < MIN_LEN);
				push_entry.kind  = K_BADLEN;
				push_entry.data  = '0;
				push_entry.ptype = '0;
				push_entry.last  = 1'b1;
			end
			PH_TYPE: begin
				push             = acc && (left_q == '0);
				push_entry.kind  = K_EMPTY;
				push_entry.data  = '0;
				push_entry.ptype = in_byte;
				push_entry.last  = 1'b1;
			end
			PH_DATA: begin
				push            = acc;
				push_entry.last = (left_q == 8'd1);
			end
			default: begin
				push = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_LEN;
			left_q  <= '0;
			chk_q   <= '0;
			type_q  <= '0;
		end else if (acc) begin
			phase_q <= phase_nx;
			case (phase_q)
				PH_LEN:  left_q <= in_byte - MIN_LEN;
				PH_CHK:  chk_q  <= in_byte;
				PH_TYPE: type_q <= in_byte;
				PH_DATA: left_q <= left_q - 8'd1;
				default: left_q <= left_q;
			endcase
		end
	end

endmodule

// ----- src/lcpd_queue.sv -----
// Small register FIFO between the parser and the checksum stage.
module lcpd_queue #(
	parameter int unsigned DEPTH = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  lcpd_pkg::entry_t  push_entry,
	output logic              full,
	input  logic              pop,
	output logic              not_empty,
	output lcpd_pkg::entry_t  head
);
	import lcpd_pkg::*;

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	entry_t           mem_q [DEPTH];
	logic [PTR_W-1:0] wr_q;
	logic [PTR_W-1:0] rd_q;
	logic [CNT_W-1:0] cnt_q;

	assign full      = (cnt_q == FULL_CNT);
	assign not_empty = (cnt_q != '0);
	assign head      = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= (wr_q == LAST_PTR) ? '0 : wr_q + 1'b1;
			if (pop)  rd_q <= (rd_q == LAST_PTR) ? '0 : rd_q + 1'b1;
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) full |-> !push)
		else $error("push into full queue");
	assert property (@(posedge clk) disable iff (!arst_n) !not_empty |-> !pop)
		else $error("pop from empty queue");

endmodule

// ----- src/lcpd_back.sv -----
// Back end: running payload sum, checksum verdict and output register.
module lcpd_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_valid,
	input  lcpd_pkg::entry_t  q_head,
	output logic              pop,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [7:0]        payload_byte,
	output logic [7:0]        packet_type,
	output logic              last,
	output logic [1:0]        status
);
	import lcpd_pkg::*;

	logic signed [SUM_W-1:0] sum_q;
	logic [RES_W-1:0]        res_q;
	logic signed [SUM_W-1:0] sum_nx;
	logic signed [9:0]       res_raw;
	logic signed [9:0]       res_fix;
	logic [RES_W-1:0]        res_nx;
	logic [RES_W-1:0]        res_chk;
	logic                    neg_chk;
	logic                    good;
	logic [1:0]              st_nx;

	logic              valid_q;
	logic [BYTE_W-1:0] data_q;
	logic [BYTE_W-1:0] type_q;
	logic              last_q;
	logic [1:0]        status_q;

	assign pop = q_valid && (!valid_q || out_ready);

	assign sum_nx  = sum_q + {{(SUM_W-BYTE_W){q_head.data[7]}}, q_head.data};
	assign res_raw = $signed({3'b000, res_q}) + $signed({{2{q_head.data[7]}}, q_head.data});

	always_comb begin
		if (res_raw < -10'sd71)       res_fix = res_raw + 10'sd142;
		else if (res_raw < 10'sd0)    res_fix = res_raw + 10'sd71;
		else if (res_raw < 10'sd71)   res_fix = res_raw;
		else if (res_raw < 10'sd142)  res_fix = res_raw - 10'sd71;
		else                          res_fix = res_raw - 10'sd142;
	end
	assign res_nx = res_fix[RES_W-1:0];

	assign res_chk = (q_head.kind == K_DATA) ? res_nx : RES_INIT;
	assign neg_chk = (q_head.kind == K_DATA) ? (sum_nx < SUM_FLOOR) : 1'b0;
	assign good    = ({1'b0, res_chk} == q_head.chk) && (!neg_chk || res_chk == '0);

	always_comb begin
		case (q_head.kind)
			K_BADLEN: st_nx = ST_BADLEN;
			K_EMPTY:  st_nx = good ? ST_GOOD : ST_BAD;
			K_DATA:   st_nx = !q_head.last ? ST_BUSY : (good ? ST_GOOD : ST_BAD);
			default:  st_nx = ST_BADLEN;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q   <= '0;
			res_q   <= RES_INIT;
			valid_q <= 1'b0;
		end else begin
			if (pop) begin
				valid_q <= 1'b1;
				if (q_head.kind == K_DATA && !q_head.last) begin
					sum_q <= sum_nx;
					res_q <= res_nx;
				end else begin
					sum_q <= '0;
					res_q <= RES_INIT;
				end
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			data_q   <= q_head.data;
			type_q   <= q_head.ptype;
			last_q   <= q_head.last;
			status_q <= st_nx;
		end
	end

	assign out_valid    = valid_q;
	assign payload_byte = data_q;
	assign packet_type  = type_q;
	assign last         = last_q;
	assign status       = status_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		valid_q |-> (last_q == (status_q != ST_BUSY)))
		else $error("last flag disagrees with status");
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && status_q == ST_BADLEN) |-> (data_q == '0 && type_q == '0))
		else $error("bad length result carries data");
	assert property (@(posedge clk) disable iff (!arst_n)
		(pop && q_head.last) |=> (sum_q == '0 && res_q == RES_INIT))
		else $error("accumulator not cleared after frame end");
	assert property (@(posedge clk) disable iff (!arst_n)
		res_q < MODULUS)
		else $error("residue out of range");

endmodule

// ----- src/length_checksum_packet_deframer_top.sv -----
// Top level of the length/checksum packet deframer.
//  channel  | dir | handshake               | payload
//  s_axis   | in  | s_axis_tvalid/tready    | tdata[7:0] in_byte
//  m_axis   | out | m_axis_tvalid/tready    | tdata payload_byte,packet_type; tlast; tuser status
// One byte per cycle sustained while the queue is not full; a result is valid at the output
// once its byte is taken and passes the queue write, then the checksum stage into the output register.
// Header bytes produce no result, apart from a bad length or an empty frame, but still wait while the queue is full.
// The input stalls only while the entry queue is full; output backpressure fills it.
// Reset clears parser phase, queue pointers, accumulator and output valid.
module length_checksum_packet_deframer_top #(
	parameter int unsigned QUEUE_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,   // [7:0] payload_byte, [15:8] packet_type
	output logic        m_axis_tlast,
	output logic [1:0]  m_axis_tuser    // [1:0] status
);
	import lcpd_pkg::*;

	logic   q_full;
	logic   push;
	entry_t push_entry;
	logic   pop;
	logic   q_valid;
	entry_t q_head;

	lcpd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.in_byte    (s_axis_tdata),
		.q_full     (q_full),
		.push       (push),
		.push_entry (push_entry)
	);

	lcpd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (q_full),
		.pop        (pop),
		.not_empty  (q_valid),
		.head       (q_head)
	);

	lcpd_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_valid      (q_valid),
		.q_head       (q_head),
		.pop          (pop),
		.out_valid    (m_axis_tvalid),
		.out_ready    (m_axis_tready),
		.payload_byte (m_axis_tdata[7:0]),
		.packet_type  (m_axis_tdata[15:8]),
		.last         (m_axis_tlast),
		.status       (m_axis_tuser)
	);

endmodule
